// File: design/tssm_pkg.sv
// ----------------------------------------------------------------------------
// tssm_pkg
// Shared types, codes and the CRC helper function of the sensor slot manager.
// ----------------------------------------------------------------------------
package tssm_pkg;

    localparam int SLOTS_DEF = 4;
    localparam int ID_BITS = 64;
    localparam int TEMP_BITS = 16;

    localparam logic [2:0] OP_LOAD     = 3'd0;
    localparam logic [2:0] OP_DISCOVER = 3'd1;
    localparam logic [2:0] OP_ID       = 3'd2;
    localparam logic [2:0] OP_ROUND    = 3'd3;
    localparam logic [2:0] OP_READING  = 3'd4;
    localparam logic [2:0] OP_QUERY    = 3'd5;

    localparam logic [1:0] ST_UNDEF = 2'd0;
    localparam logic [1:0] ST_OK    = 2'd1;
    localparam logic [1:0] ST_NOK   = 2'd2;
    localparam logic [1:0] ST_AUTO  = 2'd3;

    localparam logic [2:0] TALLY_MAX = 3'd7;
    localparam logic [7:0] CRC_POLY = 8'h8C;

    typedef struct packed {
        logic clear;
        logic crc_step;
        logic scan_step;
        logic apply;
    } t_cmd;

    typedef struct packed {
        logic crc_done;
        logic scan_done;
    } t_stat;

    function automatic logic [7:0] crc_bit(input logic [7:0] crc, input logic d);
        logic mix;
        logic [7:0] c;
        mix = crc[0] ^ d;
        c = {1'b0, crc[7:1]};
        if (mix) begin
            c = c ^ CRC_POLY;
        end
        return c;
    endfunction

endpackage

// File: design/tssm_ctrl.sv
// ----------------------------------------------------------------------------
// tssm_ctrl
// Sequencer: CRC phase, slot scan phase, commit and result delivery.
// ----------------------------------------------------------------------------
module tssm_ctrl
    import tssm_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    output logic  o_valid,
    input  logic  i_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [2:0] {S_IDLE, S_CRC, S_SCAN, S_APPLY, S_OUT} t_state;

    t_state r_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_state <= S_CRC;
                    end
                end
                S_CRC: begin
                    if (i_stat.crc_done) begin
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (i_stat.scan_done) begin
                        r_state <= S_APPLY;
                    end
                end
                S_APPLY: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (i_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_OUT);
    assign o_cmd.clear = (r_state == S_IDLE) && i_valid;
    assign o_cmd.crc_step = (r_state == S_CRC);
    assign o_cmd.scan_step = (r_state == S_SCAN);
    assign o_cmd.apply = (r_state == S_APPLY);

endmodule

// File: design/tssm_dp.sv
// ----------------------------------------------------------------------------
// tssm_dp
// Slot table, bit-serial CRC-8 engines, slot search and temperature convert.
// ----------------------------------------------------------------------------
module tssm_dp
    import tssm_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    input  logic [2:0]  i_operation,
    input  logic [1:0]  i_slot_index,
    input  logic [63:0] i_rom_code,
    input  logic [63:0] i_scratch_bytes,
    input  logic [7:0]  i_scratch_crc,
    input  logic signed [15:0] i_range_min,
    input  logic signed [15:0] i_range_max,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    output logic        o_accepted,
    output logic [1:0]  o_hit_slot,
    output logic [1:0]  o_slot_status,
    output logic signed [15:0] o_slot_temp,
    output logic [3:0]  o_resolution_bits,
    output logic [2:0]  o_matched_count
);

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);

    logic [15:0] r_undef;
    logic [63:0] r_id [SLOTS];
    logic [1:0]  r_st [SLOTS];
    logic [15:0] r_lo [SLOTS];
    logic [15:0] r_hi [SLOTS];
    logic [15:0] r_rd [SLOTS];
    logic [2:0]  r_tally;

    logic [2:0]  r_op;
    logic [1:0]  r_idx;
    logic [63:0] r_rom;
    logic [63:0] r_sp;
    logic [63:0] r_rsh;
    logic [63:0] r_ssh;
    logic [7:0]  r_spcrc;
    logic [15:0] r_rmin;
    logic [15:0] r_rmax;
    logic [6:0]  r_bitcnt;
    logic [7:0]  r_crc_id;
    logic [7:0]  r_crc_sp;
    logic [CW-1:0] r_scan;
    logic        r_fm;
    logic [SW-1:0] r_fm_i;
    logic        r_fz;
    logic [SW-1:0] r_fz_i;
    logic signed [19:0] r_tconv;
    logic [3:0]  r_res;

    logic        r_acc;
    logic [1:0]  r_hit;
    logic [1:0]  r_ost;
    logic [15:0] r_otmp;
    logic [3:0]  r_ores;

    logic [SW-1:0] w_scan_i;
    logic [15:0] w_raw;
    logic [3:0]  w_res;
    logic signed [21:0] w_prod;
    logic signed [19:0] w_t;
    logic [15:0] w_tb;
    logic        w_idok;
    logic        w_spok;
    logic        w_idx_ok;
    logic [SW-1:0] w_idx;

    assign w_scan_i = r_scan[SW-1:0];
    assign w_idx = SW'(r_idx);
    assign w_idx_ok = ({30'd0, r_idx} < 32'(SLOTS));
    assign w_idok = (r_crc_id == r_rom[63:56]);
    assign w_spok = (r_crc_sp == r_spcrc);
    assign o_stat.crc_done = (r_bitcnt == 7'd63);
    assign o_stat.scan_done = (r_scan == CW'(SLOTS - 1)) || (SLOTS == 1);

    always_comb begin
        w_raw = r_sp[15:0];
        unique case (r_sp[38:37])
            2'd0: begin
                w_raw[2:0] = 3'd0;
                w_res = 4'd9;
            end
            2'd1: begin
                w_raw[1:0] = 2'd0;
                w_res = 4'd10;
            end
            2'd2: begin
                w_raw[0] = 1'b0;
                w_res = 4'd11;
            end
            default: begin
                w_res = 4'd12;
            end
        endcase
        w_prod = 22'($signed(w_raw)) * 22'sd25;
        if (w_prod < 0) begin
            w_prod = w_prod + 22'sd3;
        end
        w_t = 20'(w_prod >>> 2);
        if (w_t > 20'sd32767) begin
            w_tb = 16'h7FFF;
        end else if (w_t < -20'sd32768) begin
            w_tb = 16'h8000;
        end else begin
            w_tb = w_t[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_undef <= 16'h8000;
            r_tally <= 3'd0;
            for (int i = 0; i < SLOTS; i++) begin
                r_id[i] <= '0;
                r_st[i] <= ST_UNDEF;
                r_lo[i] <= 16'h8000;
                r_hi[i] <= 16'h8000;
                r_rd[i] <= 16'h8000;
            end
        end else begin
            if (i_cfg_we) begin
                r_undef <= i_cfg_data;
            end
            if (i_cmd.apply) begin
                r_acc <= 1'b0;
                r_hit <= 2'd0;
                r_ost <= 2'd0;
                r_otmp <= 16'd0;
                r_ores <= 4'd0;
                unique case (r_op)
                    OP_LOAD: begin
                        if (w_idx_ok) begin
                            r_id[w_idx] <= r_rom;
                            r_st[w_idx] <= (r_rom == 64'd0) ? ST_UNDEF : ST_NOK;
                            r_lo[w_idx] <= r_rmin;
                            r_hi[w_idx] <= r_rmax;
                            r_rd[w_idx] <= r_undef;
                            r_acc <= 1'b1;
                            r_hit <= r_idx;
                            r_ost <= (r_rom == 64'd0) ? ST_UNDEF : ST_NOK;
                            r_otmp <= r_undef;
                        end
                    end
                    OP_DISCOVER: begin
                        for (int i = 0; i < SLOTS; i++) begin
                            if (r_id[i] == 64'd0) begin
                                r_st[i] <= ST_UNDEF;
                            end
                        end
                        r_tally <= 3'd0;
                    end
                    OP_ID: begin
                        if (w_idok && (r_fm || r_fz)) begin
                            r_acc <= 1'b1;
                            r_ost <= r_fm ? ST_OK : ST_AUTO;
                            if (r_tally != TALLY_MAX) begin
                                r_tally <= r_tally + 3'd1;
                            end
                            if (r_fm) begin
                                r_st[r_fm_i] <= ST_OK;
                                r_hit <= 2'(r_fm_i);
                                r_otmp <= r_rd[r_fm_i];
                            end else begin
                                r_id[r_fz_i] <= r_rom;
                                r_st[r_fz_i] <= ST_AUTO;
                                r_hit <= 2'(r_fz_i);
                                r_otmp <= r_rd[r_fz_i];
                            end
                        end
                    end
                    OP_ROUND: begin
                        for (int i = 0; i < SLOTS; i++) begin
                            if (r_st[i] == ST_OK) begin
                                r_st[i] <= ST_NOK;
                            end
                            r_rd[i] <= r_undef;
                        end
                    end
                    OP_READING: begin
                        if (w_idok && w_spok && r_fm) begin
                            r_acc <= 1'b1;
                            r_hit <= 2'(r_fm_i);
                            r_ores <= r_res;
                            r_ost <= r_st[r_fm_i];
                            r_otmp <= r_rd[r_fm_i];
                            if (r_st[r_fm_i] == ST_AUTO) begin
                                r_rd[r_fm_i] <= r_tconv[15:0];
                                r_otmp <= r_tconv[15:0];
                            end else if (r_st[r_fm_i] == ST_NOK) begin
                                if ((r_lo[r_fm_i] == r_undef ||
                                     r_tconv >= 20'($signed(r_lo[r_fm_i]))) &&
                                    (r_hi[r_fm_i] == r_undef ||
                                     r_tconv <= 20'($signed(r_hi[r_fm_i])))) begin
                                    r_st[r_fm_i] <= ST_OK;
                                    r_rd[r_fm_i] <= r_tconv[15:0];
                                    r_ost <= ST_OK;
                                    r_otmp <= r_tconv[15:0];
                                end
                            end
                        end
                    end
                    OP_QUERY: begin
                        if (w_idx_ok) begin
                            r_acc <= 1'b1;
                            r_hit <= r_idx;
                            r_ost <= r_st[w_idx];
                            r_otmp <= r_rd[w_idx];
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clear) begin
            r_op <= i_operation;
            r_idx <= i_slot_index;
            r_rom <= i_rom_code;
            r_sp <= i_scratch_bytes;
            r_rsh <= i_rom_code;
            r_ssh <= i_scratch_bytes;
            r_spcrc <= i_scratch_crc;
            r_rmin <= i_range_min;
            r_rmax <= i_range_max;
            r_bitcnt <= 7'd0;
            r_crc_id <= 8'd0;
            r_crc_sp <= 8'd0;
            r_scan <= '0;
            r_fm <= 1'b0;
            r_fz <= 1'b0;
            r_fm_i <= '0;
            r_fz_i <= '0;
        end
        if (i_cmd.crc_step) begin
            r_bitcnt <= r_bitcnt + 7'd1;
            r_rsh <= {1'b0, r_rsh[63:1]};
            r_ssh <= {1'b0, r_ssh[63:1]};
            if (r_bitcnt < 7'd56) begin
                r_crc_id <= crc_bit(r_crc_id, r_rsh[0]);
            end
            r_crc_sp <= crc_bit(r_crc_sp, r_ssh[0]);
            r_tconv <= $signed({{4{w_tb[15]}}, w_tb});
            r_res <= w_res;
        end
        if (i_cmd.scan_step || (i_cmd.crc_step && o_stat.crc_done)) begin
            if (!(i_cmd.crc_step)) begin
                r_scan <= r_scan + CW'(1);
                if (!r_fm && r_id[w_scan_i] == r_rom) begin
                    r_fm <= 1'b1;
                    r_fm_i <= w_scan_i;
                end
                if (!r_fz && r_id[w_scan_i] == 64'd0) begin
                    r_fz <= 1'b1;
                    r_fz_i <= w_scan_i;
                end
            end
        end
    end

    assign o_accepted = r_acc;
    assign o_hit_slot = r_hit;
    assign o_slot_status = r_ost;
    assign o_slot_temp = r_otmp;
    assign o_resolution_bits = r_ores;
    assign o_matched_count = r_tally;

endmodule

// File: design/temp_sensor_slot_manager.sv
// The earliest result beat comes after the input beat through 64 serial CRC steps,
// a slot search over each slot in turn and one commit.
// One item at a time: no new item is taken until the result beat is accepted.
// Reset: synchronous active low; slots return to an undefined ID with
// sentinel temperatures and bounds, the tally clears and the sentinel is -32768.
// ----------------------------------------------------------------------------
// temp_sensor_slot_manager
// Top level of the sensor slot table with CRC checking and readout validation.
// ----------------------------------------------------------------------------
module temp_sensor_slot_manager
    import tssm_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_operation,
    input  logic [1:0]  i_slot_index,
    input  logic [63:0] i_rom_code,
    input  logic [63:0] i_scratch_bytes,
    input  logic [7:0]  i_scratch_crc,
    input  logic signed [15:0] i_range_min,
    input  logic signed [15:0] i_range_max,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_accepted,
    output logic [1:0]  o_hit_slot,
    output logic [1:0]  o_slot_status,
    output logic signed [15:0] o_slot_temp,
    output logic [3:0]  o_resolution_bits,
    output logic [2:0]  o_matched_count
);

    t_cmd  w_cmd;
    t_stat w_stat;

    tssm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    tssm_dp #(.SLOTS(SLOTS)) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_data        (i_cfg_data),
        .i_operation       (i_operation),
        .i_slot_index      (i_slot_index),
        .i_rom_code        (i_rom_code),
        .i_scratch_bytes   (i_scratch_bytes),
        .i_scratch_crc     (i_scratch_crc),
        .i_range_min       (i_range_min),
        .i_range_max       (i_range_max),
        .i_cmd             (w_cmd),
        .o_stat            (w_stat),
        .o_accepted        (o_accepted),
        .o_hit_slot        (o_hit_slot),
        .o_slot_status     (o_slot_status),
        .o_slot_temp       (o_slot_temp),
        .o_resolution_bits (o_resolution_bits),
        .o_matched_count   (o_matched_count)
    );

endmodule

// File: design/tssm_checker.sv
// ----------------------------------------------------------------------------
// tssm_checker
// Port-level checks of the slot manager, bound to the top level.
// ----------------------------------------------------------------------------
module tssm_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_ready,
    input logic       o_valid,
    input logic       i_ready,
    input logic       o_accepted,
    input logic [1:0] o_hit_slot,
    input logic [3:0] o_resolution_bits
);

    a_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_hit_slot))
        else $error("result beat changed while stalled");

    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_valid && o_ready))
        else $error("ready while a result is pending");

    a_noacc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_accepted |-> o_hit_slot == 2'd0 && o_resolution_bits == 4'd0)
        else $error("fields not cleared on a miss");

    a_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_valid)
        else $error("result appeared right after a beat");

endmodule

bind temp_sensor_slot_manager tssm_checker u_tssm_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_valid           (i_valid),
    .o_ready           (o_ready),
    .o_valid           (o_valid),
    .i_ready           (i_ready),
    .o_accepted        (o_accepted),
    .o_hit_slot        (o_hit_slot),
    .o_resolution_bits (o_resolution_bits)
);
